@@ hdl/afk_pkg.sv @@
// shared types, constants and arithmetic helpers for the arm forward kinematics block
// no dependencies
`default_nettype none

package afk_pkg;

   localparam int FRAC = 24;
   localparam int ITERS = 24;
   localparam int NJ = 7;
   localparam int CHAIN = NJ + 1;
   localparam int EW = 27;
   localparam int AW = 17;
   localparam int ANG_FRAC_SHIFT = 11;
   localparam int VW = AW + ANG_FRAC_SHIFT;
   localparam int JW = 16;
   localparam int POS_W = 18;
   localparam int ANG_W = 16;
   localparam int PITCH_W = 15;

   localparam int ROT_LAT = ITERS + 2;
   localparam int VEC_LAT = ITERS + 1;
   localparam int TOTAL = ROT_LAT + CHAIN + 2 * VEC_LAT + 2;

   typedef logic signed [EW-1:0] entry_type;
   typedef logic signed [VW-1:0] wide_type;
   typedef logic signed [2*EW:0] prod_type;
   typedef logic [1:0] axis_type;

   typedef struct packed {
      entry_type a;
      entry_type b;
   } pair_type;

   localparam entry_type Q_ONE = 27'sd16777216;
   localparam entry_type Q_GAIN = 27'sd10188014;
   localparam entry_type Q_TILT = 27'sd11863283;
   localparam wide_type Q_PI = 28'sd52707179;
   localparam wide_type Q_HALF_PI = 28'sd26353589;

   localparam entry_type LEN_UPPER = 27'sd4314513;
   localparam entry_type LEN_FORE = 27'sd4353184;
   localparam entry_type LEN_WRIST = 27'sd1409286;
   localparam entry_type LEN_TAB [CHAIN] = '{
      27'sd0, 27'sd0, 27'sd0, LEN_UPPER, 27'sd0, LEN_FORE, 27'sd0, LEN_WRIST};

   localparam longint ROUND_L = 64'sd8388608;
   localparam longint LS_QT = 64'sd2620014 * 64'sd11863283;
   localparam entry_type P_TILT_POS = entry_type'(-((LS_QT + ROUND_L) >>> FRAC));
   localparam entry_type P_TILT_NEG = entry_type'(-((ROUND_L - LS_QT) >>> FRAC));

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;
   localparam axis_type AXIS_TAB [NJ] = '{
      AXIS_Z, AXIS_Y, AXIS_X, AXIS_Y, AXIS_Z, AXIS_X, AXIS_Y};
   localparam axis_type PAIR_A [3] = '{2'd1, 2'd0, 2'd0};
   localparam axis_type PAIR_B [3] = '{2'd2, 2'd2, 2'd1};
   localparam logic MIRROR_TAB [NJ] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

   localparam wide_type ATAN_TAB [ITERS] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384,
      28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
      28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2};

   localparam prod_type PROD_RND = 55'sd8388608;
   localparam wide_type ANG_RND = 28'sd1024;
   localparam int ANG_SHIFT = 11;
   localparam wide_type ROLL_LIM = 28'sd25736;
   localparam wide_type PITCH_LIM = 28'sd12868;
   localparam wide_type POS_RND = 28'sd128;
   localparam int POS_SHIFT = 8;
   localparam wide_type POS_MAX = 28'sd131071;
   localparam wide_type POS_MIN = -28'sd131072;

   function automatic entry_type rnd_q(input prod_type v);
      prod_type t;
      t = (v + PROD_RND) >>> FRAC;
      return t[EW-1:0];
   endfunction

   function automatic pair_type rot_pair(input entry_type ra, input entry_type rb,
                                         input entry_type c, input entry_type s);
      prod_type ta;
      prod_type tb;
      pair_type r;
      ta = ra * c - rb * s;
      tb = ra * s + rb * c;
      r.a = rnd_q(ta);
      r.b = rnd_q(tb);
      return r;
   endfunction

   function automatic logic signed [ANG_W-1:0] sat_angle(input wide_type a, input wide_type lim);
      wide_type t;
      wide_type r;
      t = (a + ANG_RND) >>> ANG_SHIFT;
      if (t > lim) begin
         r = lim;
      end else if (t < -lim) begin
         r = -lim;
      end else begin
         r = t;
      end
      return r[ANG_W-1:0];
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input wide_type p);
      wide_type t;
      wide_type r;
      t = (p + POS_RND) >>> POS_SHIFT;
      if (t > POS_MAX) begin
         r = POS_MAX;
      end else if (t < POS_MIN) begin
         r = POS_MIN;
      end else begin
         r = t;
      end
      return r[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/afk_if.sv @@
// handshake channels of the arm forward kinematics block: request, response, csr write
// depends on afk_pkg
`default_nettype none

interface afk_req_if;
   logic valid;
   logic ready;
   logic signed [afk_pkg::JW-1:0] joint_angle_1;
   logic signed [afk_pkg::JW-1:0] joint_angle_2;
   logic signed [afk_pkg::JW-1:0] joint_angle_3;
   logic signed [afk_pkg::JW-1:0] joint_angle_4;
   logic signed [afk_pkg::JW-1:0] joint_angle_5;
   logic signed [afk_pkg::JW-1:0] joint_angle_6;
   logic signed [afk_pkg::JW-1:0] joint_angle_7;
   modport source (output valid, joint_angle_1, joint_angle_2, joint_angle_3, joint_angle_4,
                   joint_angle_5, joint_angle_6, joint_angle_7, input ready);
   modport sink (input valid, joint_angle_1, joint_angle_2, joint_angle_3, joint_angle_4,
                 joint_angle_5, joint_angle_6, joint_angle_7, output ready);
endinterface

interface afk_rsp_if;
   logic valid;
   logic ready;
   logic signed [afk_pkg::POS_W-1:0] pos_x;
   logic signed [afk_pkg::POS_W-1:0] pos_y;
   logic signed [afk_pkg::POS_W-1:0] pos_z;
   logic signed [afk_pkg::ANG_W-1:0] roll_angle;
   logic signed [afk_pkg::PITCH_W-1:0] pitch_angle;
   logic signed [afk_pkg::ANG_W-1:0] yaw_angle;
   modport source (output valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
                 output ready);
endinterface

interface afk_csr_if;
   logic valid;
   logic ready;
   logic arm_side;
   modport source (output valid, arm_side, input ready);
   modport sink (input valid, arm_side, output ready);
endinterface

`default_nettype wire

@@ hdl/afk_sincos.sv @@
// pipelined rotation-mode cordic: quadrant fold, one iteration per stage, sign fixup
// depends on afk_pkg
`default_nettype none

module afk_sincos (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [afk_pkg::AW-1:0]  angle,
   output afk_pkg::entry_type             sin_val,
   output afk_pkg::entry_type             cos_val
);
   import afk_pkg::*;

   entry_type x_ff [ITERS+1];
   entry_type y_ff [ITERS+1];
   wide_type  z_ff [ITERS];
   logic      flip_ff [ITERS+1];
   entry_type x_in [ITERS+1];
   entry_type y_in [ITERS+1];
   wide_type  z_in [ITERS];
   logic      flip_in [ITERS+1];
   wide_type  z_raw;
   entry_type sin_ff;
   entry_type cos_ff;

   always_comb begin
      z_raw = {angle, {ANG_FRAC_SHIFT{1'b0}}};
      x_in[0] = Q_GAIN;
      y_in[0] = '0;
      z_in[0] = z_raw;
      flip_in[0] = 1'b0;
      if (z_raw > Q_HALF_PI) begin
         z_in[0] = z_raw - Q_PI;
         flip_in[0] = 1'b1;
      end else if (z_raw < -Q_HALF_PI) begin
         z_in[0] = z_raw + Q_PI;
         flip_in[0] = 1'b1;
      end
      for (int i = 0; i < ITERS; i++) begin
         flip_in[i+1] = flip_ff[i];
         if (z_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
         end
         if (i < ITERS - 1) begin
            z_in[i+1] = (z_ff[i] >= 0) ? z_ff[i] - ATAN_TAB[i] : z_ff[i] + ATAN_TAB[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= ITERS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            flip_ff[i] <= flip_in[i];
         end
         for (int i = 0; i < ITERS; i++) begin
            z_ff[i] <= z_in[i];
         end
         sin_ff <= flip_ff[ITERS] ? -y_ff[ITERS] : y_ff[ITERS];
         cos_ff <= flip_ff[ITERS] ? -x_ff[ITERS] : x_ff[ITERS];
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

`default_nettype wire

@@ hdl/afk_atan2.sv @@
// pipelined vectoring-mode cordic: quarter-turn pre-rotation, one iteration per stage
// depends on afk_pkg
`default_nettype none

module afk_atan2 (
   input  logic              clock,
   input  logic              en,
   input  afk_pkg::wide_type y_val,
   input  afk_pkg::wide_type x_val,
   output afk_pkg::wide_type angle,
   output afk_pkg::wide_type mag
);
   import afk_pkg::*;

   wide_type x_ff [ITERS+1];
   wide_type y_ff [ITERS];
   wide_type z_ff [ITERS+1];
   logic     zero_ff [ITERS+1];
   wide_type x_in [ITERS+1];
   wide_type y_in [ITERS];
   wide_type z_in [ITERS+1];
   logic     zero_in [ITERS+1];

   always_comb begin
      x_in[0] = x_val;
      y_in[0] = y_val;
      z_in[0] = '0;
      zero_in[0] = (x_val == 0) && (y_val == 0);
      if (x_val < 0) begin
         if (y_val >= 0) begin
            x_in[0] = y_val;
            y_in[0] = -x_val;
            z_in[0] = Q_HALF_PI;
         end else begin
            x_in[0] = -y_val;
            y_in[0] = x_val;
            z_in[0] = -Q_HALF_PI;
         end
      end
      for (int i = 0; i < ITERS; i++) begin
         zero_in[i+1] = zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + ATAN_TAB[i];
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - ATAN_TAB[i];
         end
         if (i < ITERS - 1) begin
            y_in[i+1] = (y_ff[i] >= 0) ? y_ff[i] - (x_ff[i] >>> i) : y_ff[i] + (x_ff[i] >>> i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= ITERS; i++) begin
            x_ff[i] <= x_in[i];
            z_ff[i] <= z_in[i];
            zero_ff[i] <= zero_in[i];
         end
         for (int i = 0; i < ITERS; i++) begin
            y_ff[i] <= y_in[i];
         end
      end
   end

   // both arguments zero give angle zero
   assign angle = zero_ff[ITERS] ? '0 : z_ff[ITERS];
   assign mag = x_ff[ITERS];

endmodule

`default_nettype wire

@@ hdl/arm_forward_kinematics_7dof.sv @@
// top level of the seven-joint arm forward kinematics pipeline
// depends on afk_pkg, afk_if, afk_sincos, afk_atan2
//
// Fully pipelined: one pose enters per clock while the output is taken, and its result
// passes through 26 stages of sine/cosine cordic, eight transform stages, two 25-stage
// vectoring cordics in series for roll and then pitch, one gain stage, one output register.
// When the output item is not taken the whole pipeline holds and the request side
// drops ready, so nothing is lost or repeated. arm_side may be written only while
// no item is in flight; csr writes are always accepted.
`default_nettype none

module arm_forward_kinematics_7dof (
   input  logic      clock,
   input  logic      reset,
   afk_req_if.sink   req_ch,
   afk_rsp_if.source rsp_ch,
   afk_csr_if.sink   csr_ch
);
   import afk_pkg::*;

   logic      adv;
   logic      arm_side_ff;
   logic      vld_ff [TOTAL];

   logic signed [JW-1:0] joint_w [NJ];
   logic signed [AW-1:0] ang_in [NJ];
   entry_type sin_w [NJ];
   entry_type cos_w [NJ];

   entry_type m_src [CHAIN][3][3];
   wide_type  p_src [CHAIN][3];
   entry_type m_in  [CHAIN][3][3];
   wide_type  p_in  [CHAIN][3];
   entry_type m_ff  [CHAIN][3][3];
   wide_type  p_ff  [CHAIN][3];

   wide_type  roll_ang, roll_mag, yaw_ang, yaw_mag, pitch_ang, pitch_mag;
   prod_type  gain_in;
   entry_type gain_ff;
   wide_type  nr20_ff [VEC_LAT+1];
   logic signed [ANG_W-1:0] roll_d_ff [VEC_LAT+1];
   logic signed [ANG_W-1:0] yaw_d_ff [VEC_LAT+1];
   logic signed [POS_W-1:0] pos_d_ff [2*VEC_LAT+1][3];
   logic signed [ANG_W-1:0] pitch_sat;

   logic signed [POS_W-1:0]   rsp_pos_x_ff, rsp_pos_y_ff, rsp_pos_z_ff;
   logic signed [ANG_W-1:0]   rsp_roll_ff, rsp_yaw_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;

   assign adv = !vld_ff[TOTAL-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   assign joint_w[0] = req_ch.joint_angle_1;
   assign joint_w[1] = req_ch.joint_angle_2;
   assign joint_w[2] = req_ch.joint_angle_3;
   assign joint_w[3] = req_ch.joint_angle_4;
   assign joint_w[4] = req_ch.joint_angle_5;
   assign joint_w[5] = req_ch.joint_angle_6;
   assign joint_w[6] = req_ch.joint_angle_7;

   // right arm negates upper arm and elbow pitch
   always_comb begin
      for (int k = 0; k < NJ; k++) begin
         ang_in[k] = AW'(joint_w[k]);
         if (arm_side_ff && MIRROR_TAB[k]) begin
            ang_in[k] = -AW'(joint_w[k]);
         end
      end
   end

   // joint k passes through k delay registers so its sine and cosine meet transform stage k
   for (genvar k = 0; k < NJ; k++) begin : g_joint
      logic signed [AW-1:0] cordic_ang;
      if (k == 0) begin : g_direct
         assign cordic_ang = ang_in[0];
      end else begin : g_delay
         logic signed [AW-1:0] tap_ff [k];
         always_ff @(posedge clock) begin
            if (adv) begin
               tap_ff[0] <= ang_in[k];
               for (int j = 1; j < k; j++) begin
                  tap_ff[j] <= tap_ff[j-1];
               end
            end
         end
         assign cordic_ang = tap_ff[k-1];
      end
      afk_sincos u_sincos (
         .clock   (clock),
         .en      (adv),
         .angle   (cordic_ang),
         .sin_val (sin_w[k]),
         .cos_val (cos_w[k])
      );
   end

   always_comb begin
      entry_type tilt;
      entry_type s_val;
      axis_type  ax;
      prod_type  off;
      pair_type  pr;
      tilt = arm_side_ff ? -Q_TILT : Q_TILT;
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            m_src[0][i][c] = '0;
         end
      end
      m_src[0][0][0] = Q_ONE;
      m_src[0][1][1] = Q_TILT;
      m_src[0][1][2] = tilt;
      m_src[0][2][1] = -tilt;
      m_src[0][2][2] = Q_TILT;
      p_src[0][0] = '0;
      p_src[0][1] = arm_side_ff ? wide_type'(P_TILT_NEG) : wide_type'(P_TILT_POS);
      p_src[0][2] = wide_type'(P_TILT_POS);
      for (int j = 1; j < CHAIN; j++) begin
         m_src[j] = m_ff[j-1];
         p_src[j] = p_ff[j-1];
      end
      for (int j = 0; j < CHAIN; j++) begin
         m_in[j] = m_src[j];
         for (int i = 0; i < 3; i++) begin
            off = LEN_TAB[j] * m_src[j][i][2];
            p_in[j][i] = p_src[j][i] - wide_type'(rnd_q(off));
         end
      end
      for (int j = 0; j < NJ; j++) begin
         ax = AXIS_TAB[j];
         s_val = (ax == AXIS_X) ? -sin_w[j] : sin_w[j];
         for (int i = 0; i < 3; i++) begin
            pr = rot_pair(m_src[j][i][PAIR_A[ax]], m_src[j][i][PAIR_B[ax]], cos_w[j], s_val);
            m_in[j][i][PAIR_A[ax]] = pr.a;
            m_in[j][i][PAIR_B[ax]] = pr.b;
         end
      end
   end

   afk_atan2 u_roll (
      .clock (clock),
      .en    (adv),
      .y_val (wide_type'(m_ff[CHAIN-1][2][1])),
      .x_val (wide_type'(m_ff[CHAIN-1][2][2])),
      .angle (roll_ang),
      .mag   (roll_mag)
   );

   afk_atan2 u_yaw (
      .clock (clock),
      .en    (adv),
      .y_val (wide_type'(m_ff[CHAIN-1][1][0])),
      .x_val (wide_type'(m_ff[CHAIN-1][0][0])),
      .angle (yaw_ang),
      .mag   (yaw_mag)
   );

   assign gain_in = roll_mag * Q_GAIN;

   afk_atan2 u_pitch (
      .clock (clock),
      .en    (adv),
      .y_val (nr20_ff[VEC_LAT]),
      .x_val (wide_type'(gain_ff)),
      .angle (pitch_ang),
      .mag   (pitch_mag)
   );

   assign pitch_sat = sat_angle(pitch_ang, PITCH_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_side_ff <= 1'b0;
         for (int i = 0; i < TOTAL; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_ch.valid) begin
            arm_side_ff <= csr_ch.arm_side;
         end
         if (adv) begin
            vld_ff[0] <= req_ch.valid;
            for (int i = 1; i < TOTAL; i++) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
         p_ff <= p_in;
         gain_ff <= rnd_q(gain_in);
         nr20_ff[0] <= -wide_type'(m_ff[CHAIN-1][2][0]);
         roll_d_ff[0] <= sat_angle(roll_ang, ROLL_LIM);
         yaw_d_ff[0] <= sat_angle(yaw_ang, ROLL_LIM);
         for (int i = 1; i <= VEC_LAT; i++) begin
            nr20_ff[i] <= nr20_ff[i-1];
            roll_d_ff[i] <= roll_d_ff[i-1];
            yaw_d_ff[i] <= yaw_d_ff[i-1];
         end
         for (int c = 0; c < 3; c++) begin
            pos_d_ff[0][c] <= sat_pos(p_ff[CHAIN-1][c]);
         end
         for (int i = 1; i <= 2 * VEC_LAT; i++) begin
            pos_d_ff[i] <= pos_d_ff[i-1];
         end
         rsp_pos_x_ff <= pos_d_ff[2*VEC_LAT][0];
         rsp_pos_y_ff <= pos_d_ff[2*VEC_LAT][1];
         rsp_pos_z_ff <= pos_d_ff[2*VEC_LAT][2];
         rsp_roll_ff <= roll_d_ff[VEC_LAT];
         rsp_yaw_ff <= yaw_d_ff[VEC_LAT];
         rsp_pitch_ff <= pitch_sat[PITCH_W-1:0];
      end
   end

   assign rsp_ch.valid = vld_ff[TOTAL-1];
   assign rsp_ch.pos_x = rsp_pos_x_ff;
   assign rsp_ch.pos_y = rsp_pos_y_ff;
   assign rsp_ch.pos_z = rsp_pos_z_ff;
   assign rsp_ch.roll_angle = rsp_roll_ff;
   assign rsp_ch.pitch_angle = rsp_pitch_ff;
   assign rsp_ch.yaw_angle = rsp_yaw_ff;

endmodule

`default_nettype wire

@@ hdl/afk_checker.sv @@
// port-level assertions for the arm forward kinematics top level, with its bind
// depends on afk_pkg and arm_forward_kinematics_7dof
`default_nettype none

module afk_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [afk_pkg::POS_W-1:0]    pos_x,
   input logic signed [afk_pkg::ANG_W-1:0]    roll_angle,
   input logic signed [afk_pkg::PITCH_W-1:0]  pitch_angle,
   input logic signed [afk_pkg::ANG_W-1:0]    yaw_angle
);
   import afk_pkg::*;

   // a stalled result stays valid and holds its pos_x and roll_angle
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(roll_angle))
      else $error("stalled result item changed");

   // a stalled result freezes the pipeline, so no new item is taken
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while output stalled");

   a_roll_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736 &&
                    yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736)
      else $error("roll or yaw out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868)
      else $error("pitch out of range");

endmodule

bind arm_forward_kinematics_7dof afk_checker u_afk_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .pos_x       (rsp_ch.pos_x),
   .roll_angle  (rsp_ch.roll_angle),
   .pitch_angle (rsp_ch.pitch_angle),
   .yaw_angle   (rsp_ch.yaw_angle)
);

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for arm_forward_kinematics_7dof: streams joint-angle items,
// predicts each pose in fixed point and compares every response field
// depends on afk_pkg, afk_if and the rtl of the block
`timescale 1ns / 1ps

module testbench;
   import afk_pkg::*;

   localparam longint ONE_Q = 64'sd16777216;
   localparam longint SHOULDER_LEN = 64'sd2620014;
   localparam int DRAIN_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic signed [JW-1:0] ang [NJ];
   } joints_type;

   typedef struct {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      logic signed [ANG_W-1:0] roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ANG_W-1:0] yaw;
   } pose_type;

   logic clock;
   logic reset;

   afk_req_if req_ch ();
   afk_rsp_if rsp_ch ();
   afk_csr_if csr_ch ();

   arm_forward_kinematics_7dof dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   joints_type joint_q [$];
   pose_type pose_q [$];
   logic right_arm;
   int snd_idle;
   int rcv_idle;
   int phase;
   int errors;
   int rsp_count;
   int stall_cycles;
   longint tf [3][3];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint rshift(input longint v, input int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic void sin_cos(input longint a13, output longint s, output longint c);
      longint z, x, y, t;
      logic flip;
      z = a13 * 2048;
      x = longint'(Q_GAIN);
      y = 0;
      flip = 1'b0;
      if (z > longint'(Q_HALF_PI)) begin
         z -= longint'(Q_PI);
         flip = 1'b1;
      end else if (z < -longint'(Q_HALF_PI)) begin
         z += longint'(Q_PI);
         flip = 1'b1;
      end
      for (int i = 0; i < ITERS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end
         x = t;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint vec_angle(input longint y0, input longint x0, output longint mag);
      longint x, y, z, t;
      x = x0;
      y = y0;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return 0;
      end
      if (x < 0) begin
         if (y >= 0) begin
            t = y; y = -x; x = t; z = longint'(Q_HALF_PI);
         end else begin
            t = -y; y = x; x = t; z = -longint'(Q_HALF_PI);
         end
      end
      for (int i = 0; i < ITERS; i++) begin
         if (y >= 0) begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end else begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end
         x = t;
      end
      mag = x;
      return z;
   endfunction

   function automatic void turn(input axis_type axis, input longint a13);
      longint s, c;
      longint e [3][3];
      longint o [3][3];
      sin_cos(a13, s, c);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            e[i][j] = (i == j) ? ONE_Q : 0;
      if (axis == AXIS_X) begin
         e[1][1] = c; e[1][2] = -s; e[2][1] = s; e[2][2] = c;
      end else if (axis == AXIS_Y) begin
         e[0][0] = c; e[0][2] = s; e[2][0] = -s; e[2][2] = c;
      end else begin
         e[0][0] = c; e[0][1] = s; e[1][0] = -s; e[1][1] = c;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            o[i][j] = rshift(tf[i][0] * e[0][j] + tf[i][1] * e[1][j] + tf[i][2] * e[2][j],
                             FRAC);
      tf = o;
   endfunction

   function automatic void shift_along(inout longint p [3], input longint len);
      for (int i = 0; i < 3; i++)
         p[i] -= rshift(len * tf[i][2], FRAC);
   endfunction

   function automatic longint clip(input longint v, input longint lim_lo, input longint lim_hi);
      return v < lim_lo ? lim_lo : (v > lim_hi ? lim_hi : v);
   endfunction

   function automatic pose_type arm_pose(input joints_type j, input logic right);
      pose_type r;
      longint q [NJ];
      longint p [3];
      longint tilt, mag, a, den;
      for (int i = 0; i < NJ; i++)
         q[i] = longint'(j.ang[i]);
      p = '{0, 0, 0};
      tilt = right ? -longint'(Q_TILT) : longint'(Q_TILT);
      tf = '{'{ONE_Q, 0, 0}, '{0, longint'(Q_TILT), tilt}, '{0, -tilt, longint'(Q_TILT)}};
      shift_along(p, SHOULDER_LEN);
      turn(AXIS_Z, q[0]);
      turn(AXIS_Y, right ? -q[1] : q[1]);
      turn(AXIS_X, q[2]);
      shift_along(p, longint'(LEN_UPPER));
      turn(AXIS_Y, right ? -q[3] : q[3]);
      turn(AXIS_Z, q[4]);
      shift_along(p, longint'(LEN_FORE));
      turn(AXIS_X, q[5]);
      turn(AXIS_Y, q[6]);
      shift_along(p, longint'(LEN_WRIST));
      r.px = POS_W'(clip(rshift(p[0], 8), -131072, 131071));
      r.py = POS_W'(clip(rshift(p[1], 8), -131072, 131071));
      r.pz = POS_W'(clip(rshift(p[2], 8), -131072, 131071));
      a = vec_angle(tf[2][1], tf[2][2], mag);
      r.roll = ANG_W'(clip(rshift(a, 11), -25736, 25736));
      den = rshift(mag * longint'(Q_GAIN), FRAC);
      a = vec_angle(-tf[2][0], den, mag);
      r.pitch = PITCH_W'(clip(rshift(a, 11), -12868, 12868));
      a = vec_angle(tf[1][0], tf[0][0], mag);
      r.yaw = ANG_W'(clip(rshift(a, 11), -25736, 25736));
      return r;
   endfunction

   function automatic logic signed [JW-1:0] pick_angle();
      int k;
      k = $urandom_range(99);
      if (k < 45) return JW'($urandom);
      if (k < 75) return JW'($signed($urandom_range(25736)) - 12868);
      if (k < 85) return JW'($signed($urandom_range(400)) - 200);
      if (k < 90) return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
      if (k < 95)
         return JW'(($signed($urandom_range(40)) + 25716) * ($urandom_range(1) ? 1 : -1));
      return JW'(($signed($urandom_range(40)) + 12848) * ($urandom_range(1) ? 1 : -1));
   endfunction

   task automatic push_random(input int n);
      joints_type j;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < NJ; i++)
            j.ang[i] = pick_angle();
         joint_q.push_back(j);
      end
   endtask

   task automatic push_same(input logic signed [JW-1:0] v);
      joints_type j;
      for (int i = 0; i < NJ; i++)
         j.ang[i] = v;
      joint_q.push_back(j);
   endtask

   task automatic push_directed();
      joints_type j;
      push_same(16'sd0);
      push_same(16'sh7fff);
      push_same(-16'sh8000);
      push_same(16'sd25736);
      push_same(-16'sd25736);
      for (int i = 0; i < NJ; i++) begin
         for (int k = 0; k < NJ; k++)
            j.ang[k] = 16'sd0;
         j.ang[i] = (i % 2) ? 16'sd12868 : -16'sd12868;
         joint_q.push_back(j);
      end
      for (int k = 0; k < NJ; k++)
         j.ang[k] = 16'sd0;
      j.ang[5] = 16'sd25736;
      joint_q.push_back(j);
      j.ang[5] = -16'sd25736;
      joint_q.push_back(j);
      j.ang[5] = 16'sd0;
      j.ang[6] = 16'sd12868;
      joint_q.push_back(j);
      j.ang[6] = -16'sd12868;
      joint_q.push_back(j);
      j.ang[1] = 16'sd12868;
      j.ang[3] = -16'sd12868;
      joint_q.push_back(j);
   endtask

   task automatic wait_drained();
      while (joint_q.size() != 0 || pose_q.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input logic v);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.arm_side <= v;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      csr_ch.valid <= 1'b0;
      right_arm = v;
   endtask

   always @(posedge clock) begin : req_driver
      joints_type j;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            j.ang[0] = req_ch.joint_angle_1;
            j.ang[1] = req_ch.joint_angle_2;
            j.ang[2] = req_ch.joint_angle_3;
            j.ang[3] = req_ch.joint_angle_4;
            j.ang[4] = req_ch.joint_angle_5;
            j.ang[5] = req_ch.joint_angle_6;
            j.ang[6] = req_ch.joint_angle_7;
            pose_q.push_back(arm_pose(j, right_arm));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (joint_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
               j = joint_q.pop_front();
               req_ch.joint_angle_1 <= j.ang[0];
               req_ch.joint_angle_2 <= j.ang[1];
               req_ch.joint_angle_3 <= j.ang[2];
               req_ch.joint_angle_4 <= j.ang[3];
               req_ch.joint_angle_5 <= j.ang[4];
               req_ch.joint_angle_6 <= j.ang[5];
               req_ch.joint_angle_7 <= j.ang[6];
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      pose_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_count++;
            if (pose_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response item at %0t", $realtime);
            end else begin
               e = pose_q.pop_front();
               if (rsp_ch.pos_x !== e.px || rsp_ch.pos_y !== e.py || rsp_ch.pos_z !== e.pz ||
                   rsp_ch.roll_angle !== e.roll || rsp_ch.pitch_angle !== e.pitch ||
                   rsp_ch.yaw_angle !== e.yaw) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                              e.px, e.py, e.pz, e.roll, e.pitch, e.yaw,
                              rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.pos_z,
                              rsp_ch.roll_angle, rsp_ch.pitch_angle, rsp_ch.yaw_angle);
               end
            end
            if (phase == 2 && rsp_count % 500 == 0)
               stall_cycles = HOLD_CYCLES;
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL arm_forward_kinematics_7dof");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.joint_angle_1 = '0;
      req_ch.joint_angle_2 = '0;
      req_ch.joint_angle_3 = '0;
      req_ch.joint_angle_4 = '0;
      req_ch.joint_angle_5 = '0;
      req_ch.joint_angle_6 = '0;
      req_ch.joint_angle_7 = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.arm_side = 1'b0;
      right_arm = 1'b0;
      errors = 0;
      rsp_count = 0;
      phase = 0;
      snd_idle = 6;
      rcv_idle = 56;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // left arm from reset, then mirrored arm, both over the directed set
      push_directed();
      push_random(350);
      wait_drained();
      write_side(1'b1);
      snd_idle = 56;
      rcv_idle = 6;
      phase = 1;
      push_directed();
      push_random(350);
      wait_drained();

      // back-pressure: long receiver hold while the sender keeps offering
      write_side(1'b0);
      snd_idle = 0;
      rcv_idle = 0;
      phase = 2;
      push_random(450);
      wait_drained();

      // sender pauses until every result is in, then resumes
      write_side(1'b1);
      phase = 3;
      push_random(150);
      while (joint_q.size() != 0 || pose_q.size() != 0 || req_ch.valid)
         @(posedge clock);
      push_random(200);
      wait_drained();

      if (errors == 0) begin
         $display("PASS arm_forward_kinematics_7dof");
      end else begin
         $display("FAIL arm_forward_kinematics_7dof");
      end
      $finish;
   end

endmodule

@@ arm_forward_kinematics_7dof.f @@
hdl/afk_pkg.sv
hdl/afk_if.sv
hdl/afk_sincos.sv
hdl/afk_atan2.sv
hdl/arm_forward_kinematics_7dof.sv
hdl/afk_checker.sv
tb/testbench.sv
